>>> rtl/grnn_kernel_regression_top_macros.svh
// Assertion macros used by the controller RTL.
`ifndef GRNN_KERNEL_REGRESSION_TOP_MACROS_SVH
`define GRNN_KERNEL_REGRESSION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GKR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GKR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GKR_ASSERT_IMP(label, clk, rst, ante, cons)
`define GKR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/gkr_pkg.sv
package gkr_pkg;

   localparam int VALW = 24;
   localparam int CSR_AW = 4;
   localparam int EXP_STEPS = 20;

   localparam logic [1:0] FUNC_LOAD_ATTR   = 2'd0;
   localparam logic [1:0] FUNC_LOAD_TARGET = 2'd1;
   localparam logic [1:0] FUNC_QUERY       = 2'd2;

   localparam logic [1:0] REG_POINT_COUNT     = 2'd0;
   localparam logic [1:0] REG_ATTRIBUTE_COUNT = 2'd1;
   localparam logic [1:0] REG_KERNEL_SCALE    = 2'd2;

   localparam logic [31:0] KERNEL_SCALE_RESET = 32'h0080_0000;

   typedef logic [29:0] exp_table_type [EXP_STEPS];

   // round(exp(-2^k / 65536) * 2^30) for each bit k of the Q.16 exponent.
   localparam exp_table_type EXP_TABLE = '{
      30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760, 30'd1073479712,
      30'd1073217664, 30'd1072693760, 30'd1071646719, 30'd1069555701, 30'd1065385899,
      30'd1057094998, 30'd1040706229, 30'd1008687096, 30'd947573834,  30'd836230973,
      30'd651257337,  30'd395007542,  30'd145315154,  30'd19666267,   30'd360200
   };

   typedef struct packed {
      logic eval_init;
      logic point_init;
      logic attr_step;
      logic scale_mul;
      logic scale_add;
      logic exp_step;
      logic accum;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic points_empty;
      logic attr_last;
      logic pipe_busy;
      logic exp_last;
      logic point_last;
      logic div_last;
   } status_type;

endpackage

>>> rtl/gkr_if.sv
interface gkr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [8:0]  point_index;
   logic [5:0]  attribute_index;
   logic signed [23:0] sample_value;
   logic        query_last;

   modport source (output valid, func, point_index, attribute_index, sample_value, query_last,
                   input ready);
   modport sink (input valid, func, point_index, attribute_index, sample_value, query_last,
                 output ready);
endinterface

interface gkr_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [23:0] prediction;
   logic        zero_weight;

   modport source (output valid, prediction, zero_weight, input ready);
   modport sink (input valid, prediction, zero_weight, output ready);
endinterface

>>> rtl/gkr_ctrl.sv
`include "grnn_kernel_regression_top_macros.svh"

module gkr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic                req_query_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gkr_pkg::cmd_type    cmd,
   input  gkr_pkg::status_type status
);
   import gkr_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_PSTART  = 11'b000_0000_0010,
      S_ATTR    = 11'b000_0000_0100,
      S_DRAIN   = 11'b000_0000_1000,
      S_SMUL    = 11'b000_0001_0000,
      S_SADD    = 11'b000_0010_0000,
      S_EXP     = 11'b000_0100_0000,
      S_ACCUM   = 11'b000_1000_0000,
      S_DIVINIT = 11'b001_0000_0000,
      S_DIV     = 11'b010_0000_0000,
      S_FINISH  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      start;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign start = req_valid && req_ready && (req_func == FUNC_QUERY) && req_query_last;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.eval_init = 1'b1;
               state_in = S_PSTART;
            end
         end
         S_PSTART: begin
            if (status.points_empty) begin
               state_in = S_DIVINIT;
            end else begin
               cmd.point_init = 1'b1;
               state_in = S_ATTR;
            end
         end
         S_ATTR: begin
            cmd.attr_step = 1'b1;
            if (status.attr_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!status.pipe_busy) state_in = S_SMUL;
         end
         S_SMUL: begin
            cmd.scale_mul = 1'b1;
            state_in = S_SADD;
         end
         S_SADD: begin
            cmd.scale_add = 1'b1;
            state_in = S_EXP;
         end
         S_EXP: begin
            cmd.exp_step = 1'b1;
            if (status.exp_last) state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in = status.point_last ? S_DIVINIT : S_PSTART;
         end
         S_DIVINIT: begin
            cmd.div_init = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            // The result register is loaded only once the previous item has left.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `GKR_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready)
   `GKR_ASSERT_NXT(a_start_walk, clock, reset, start, state_ff == S_PSTART)
   `GKR_ASSERT_NXT(a_attr_end, clock, reset, cmd.attr_step && status.attr_last,
                   state_ff == S_DRAIN)
   `GKR_ASSERT_NXT(a_last_point, clock, reset, cmd.accum && status.point_last,
                   state_ff == S_DIVINIT)

endmodule

>>> rtl/gkr_datapath.sv
module gkr_datapath #(
   parameter int MAX_POINTS = 512,
   parameter int MAX_ATTRIBUTES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_write,
   input  logic [1:0]          req_func,
   input  logic [8:0]          point_index,
   input  logic [5:0]          attribute_index,
   input  logic signed [23:0]  sample_value,
   input  logic [9:0]          point_count,
   input  logic [6:0]          attribute_count,
   input  logic [31:0]         kernel_scale,
   input  gkr_pkg::cmd_type    cmd,
   output gkr_pkg::status_type status,
   output logic signed [23:0]  prediction,
   output logic                zero_weight
);
   import gkr_pkg::*;

   localparam int PIW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int JW = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
   localparam int DEPTH = MAX_POINTS * MAX_ATTRIBUTES;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DISTW = 50 + $clog2(MAX_ATTRIBUTES + 1);
   localparam int HIW = DISTW - 38;
   localparam int PHW = HIW + 33;
   localparam int SUMW = 17 + $clog2(MAX_POINTS + 1);
   localparam int WSW = 41 + $clog2(MAX_POINTS + 1);
   localparam int DCW = $clog2(WSW + 1);

   logic signed [VALW-1:0] attr_mem [DEPTH];
   logic signed [VALW-1:0] targ_mem [MAX_POINTS];
   logic signed [VALW-1:0] query_mem [MAX_ATTRIBUTES];

   logic signed [VALW-1:0] attr_q_ff, targ_q_ff, query_q_ff;
   logic [PIW-1:0]   p_ff;
   logic [AW-1:0]    base_ff;
   logic [JW-1:0]    j_ff;
   logic             rv1_ff, rv2_ff;
   logic [49:0]      sq_ff;
   logic [DISTW-1:0] dist_ff;
   logic [HIW+31:0]  prod_hi_ff;
   logic [55:0]      prod_lo_ff;
   logic [19:0]      a_ff;
   logic             big_ff;
   logic [30:0]      acc_ff;
   logic [4:0]       k_ff;
   logic signed [WSW-1:0] wsum_ff;
   logic [SUMW-1:0]  sum_ff;
   logic             neg_ff;
   logic [WSW-1:0]   num_ff;
   logic [SUMW:0]    rem_ff;
   logic [DCW-1:0]   dcnt_ff;
   logic signed [23:0] pred_ff;
   logic             zw_ff;

   logic             pok, aok;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [8:0]       na;
   logic [12:0]      np;
   logic signed [24:0] diff;
   logic [PHW-1:0]   a_sum;
   logic [60:0]      eprod;
   logic [31:0]      wrnd;
   logic [16:0]      weight;
   logic signed [41:0] wprod;
   logic [WSW-1:0]   mag;
   logic [SUMW:0]    trial;
   logic             qbit;

   assign pok = 32'(point_index) < MAX_POINTS;
   assign aok = 32'(attribute_index) < MAX_ATTRIBUTES;
   assign wr_addr = AW'(32'(point_index) * MAX_ATTRIBUTES + 32'(attribute_index));
   assign rd_addr = base_ff + AW'(j_ff);

   always_ff @(posedge clock) begin
      if (req_write && req_func == FUNC_LOAD_ATTR && pok && aok) begin
         attr_mem[wr_addr] <= sample_value;
      end
      attr_q_ff <= attr_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (req_write && req_func == FUNC_LOAD_TARGET && pok) begin
         targ_mem[PIW'(point_index)] <= sample_value;
      end
      targ_q_ff <= targ_mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (req_write && req_func == FUNC_QUERY && aok) begin
         query_mem[JW'(attribute_index)] <= sample_value;
      end
      query_q_ff <= query_mem[j_ff];
   end

   assign na = (9'(attribute_count) > 9'(MAX_ATTRIBUTES)) ? 9'(MAX_ATTRIBUTES)
                                                          : 9'(attribute_count);
   assign np = (13'(point_count) > 13'(MAX_POINTS)) ? 13'(MAX_POINTS) : 13'(point_count);

   assign status.points_empty = (np == 13'd0);
   assign status.attr_last = (na == 9'd0) || (9'(j_ff) == na - 9'd1);
   assign status.pipe_busy = rv1_ff | rv2_ff;
   assign status.exp_last = (k_ff == 5'(EXP_STEPS - 1));
   assign status.point_last = (13'(p_ff) == np - 13'd1);
   assign status.div_last = (dcnt_ff == DCW'(WSW - 1));

   assign diff = 25'(query_q_ff) - 25'(attr_q_ff);
   assign a_sum = PHW'(prod_hi_ff) + PHW'(prod_lo_ff[55:24]);
   assign eprod = 61'(acc_ff) * 61'(EXP_TABLE[k_ff]);
   assign wrnd = 32'(acc_ff) + 32'h0000_2000;
   assign weight = big_ff ? 17'd0 : wrnd[30:14];
   assign wprod = $signed({1'b0, weight}) * targ_q_ff;
   assign mag = wsum_ff[WSW-1] ? WSW'(-wsum_ff) : WSW'(wsum_ff);
   assign trial = {rem_ff[SUMW-1:0], num_ff[WSW-1]};
   assign qbit = (trial >= {1'b0, sum_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         rv1_ff <= 1'b0;
         rv2_ff <= 1'b0;
      end else begin
         rv1_ff <= cmd.attr_step && (na != 9'd0);
         rv2_ff <= rv1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= 50'(diff) * 50'(diff);
      if (cmd.eval_init) begin
         p_ff <= '0;
         base_ff <= '0;
         wsum_ff <= '0;
         sum_ff <= '0;
      end
      if (cmd.point_init) begin
         j_ff <= '0;
         dist_ff <= '0;
      end
      if (cmd.attr_step) j_ff <= j_ff + 1'b1;
      if (rv2_ff) dist_ff <= dist_ff + DISTW'(sq_ff);
      if (cmd.scale_mul) begin
         prod_hi_ff <= dist_ff[DISTW-1:38] * kernel_scale;
         prod_lo_ff <= dist_ff[37:14] * kernel_scale;
      end
      if (cmd.scale_add) begin
         big_ff <= |a_sum[PHW-1:20];
         a_ff <= a_sum[19:0];
         acc_ff <= 31'h4000_0000;
         k_ff <= '0;
      end
      if (cmd.exp_step) begin
         if (a_ff[k_ff]) acc_ff <= 31'((eprod + 61'h2000_0000) >> 30);
         k_ff <= k_ff + 5'd1;
      end
      if (cmd.accum) begin
         wsum_ff <= wsum_ff + WSW'(wprod);
         sum_ff <= sum_ff + SUMW'(weight);
         p_ff <= p_ff + 1'b1;
         base_ff <= base_ff + AW'(MAX_ATTRIBUTES);
      end
      if (cmd.div_init) begin
         neg_ff <= wsum_ff[WSW-1];
         num_ff <= mag + WSW'(sum_ff >> 1);
         rem_ff <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? (trial - {1'b0, sum_ff}) : trial;
         num_ff <= {num_ff[WSW-2:0], qbit};
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         if (sum_ff == '0) begin
            pred_ff <= '0;
            zw_ff <= 1'b1;
         end else begin
            zw_ff <= 1'b0;
            if (neg_ff) begin
               pred_ff <= (num_ff > WSW'(32'h0080_0000)) ? 24'sh800000 : -$signed(num_ff[23:0]);
            end else begin
               pred_ff <= (num_ff > WSW'(32'h007F_FFFF)) ? 24'sh7FFFFF : $signed(num_ff[23:0]);
            end
         end
      end
   end

   assign prediction = pred_ff;
   assign zero_weight = zw_ff;

endmodule

>>> rtl/grnn_kernel_regression_top.sv
// Kernel regression engine over a stored training set.
// The req channel carries three kinds of item: a training attribute load, a
// training target load, and one query attribute. Load and query items are
// taken in one cycle each while the block is idle. A query item with
// query_last set starts an evaluation, and ready stays low until it ends.
// For P points and A attributes, an evaluation walks the points in turn: each
// point walks its attributes through the single attribute memory port, then
// runs through the bit-serial exponential unit. The final mean comes from a
// 51-step restoring divider.
// The result item leaves on the rsp channel from an output register. While it
// waits there the block keeps taking new items; a further result waits in
// the last state until the register is free.
// The APB port sets point_count, attribute_count and kernel_scale; write it
// only while the block is idle. Synchronous reset clears the controller and
// the registers; training and query stores keep their contents and must be
// written before they are used.
module grnn_kernel_regression_top #(
   parameter int MAX_POINTS = 512,
   parameter int MAX_ATTRIBUTES = 64
) (
   input  logic         clock,
   input  logic         reset,
   gkr_req_if.sink      req,
   gkr_rsp_if.source    rsp,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [gkr_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import gkr_pkg::*;

   logic [9:0]  point_count_ff;
   logic [6:0]  attribute_count_ff;
   logic [31:0] kernel_scale_ff;
   logic        csr_write;
   cmd_type     cmd;
   status_type  status;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         attribute_count_ff <= 7'd1;
         kernel_scale_ff <= KERNEL_SCALE_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_POINT_COUNT:     point_count_ff <= pwdata[9:0];
            REG_ATTRIBUTE_COUNT: attribute_count_ff <= pwdata[6:0];
            REG_KERNEL_SCALE:    kernel_scale_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_POINT_COUNT:     prdata = 32'(point_count_ff);
         REG_ATTRIBUTE_COUNT: prdata = 32'(attribute_count_ff);
         REG_KERNEL_SCALE:    prdata = kernel_scale_ff;
         default:             prdata = '0;
      endcase
   end

   gkr_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_func       (req.func),
      .req_query_last (req.query_last),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .cmd            (cmd),
      .status         (status)
   );

   gkr_datapath #(
      .MAX_POINTS     (MAX_POINTS),
      .MAX_ATTRIBUTES (MAX_ATTRIBUTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_write       (req.valid && req.ready),
      .req_func        (req.func),
      .point_index     (req.point_index),
      .attribute_index (req.attribute_index),
      .sample_value    (req.sample_value),
      .point_count     (point_count_ff),
      .attribute_count (attribute_count_ff),
      .kernel_scale    (kernel_scale_ff),
      .cmd             (cmd),
      .status          (status),
      .prediction      (rsp.prediction),
      .zero_weight     (rsp.zero_weight)
   );

endmodule

>>> test/gkr_checker.sv
module gkr_checker (
   input  logic        clock,
   input  logic        reset,
   gkr_req_if          req,
   gkr_rsp_if          rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [gkr_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0] pwdata,
   output int          error_count,
   output int          pending_count
);
   import gkr_pkg::*;

   localparam int NPTS = 512;
   localparam int NATS = 64;

   typedef struct {
      logic signed [23:0] prediction;
      logic               zero_weight;
   } estimate_type;

   logic signed [23:0] attr_store [NPTS*NATS];
   logic signed [23:0] target_store [NPTS];
   logic signed [23:0] query_store [NATS];
   logic [9:0]  point_count;
   logic [6:0]  attribute_count;
   logic [31:0] kernel_scale;
   estimate_type estimates [$];

   assign pending_count = estimates.size();

   // Weighted mean of the targets over all points in use.
   function automatic estimate_type predict_mean();
      estimate_type est;
      int np, na;
      longint diff;
      longint unsigned sq_dist, d16, a, acc, w, wsum_mag, wsum_sum, q;
      longint wsum;
      np = (point_count > NPTS) ? NPTS : point_count;
      na = (attribute_count > NATS) ? NATS : attribute_count;
      wsum = 0;
      wsum_sum = 0;
      for (int p = 0; p < np; p++) begin
         sq_dist = 0;
         for (int j = 0; j < na; j++) begin
            diff = longint'(query_store[j]) - longint'(attr_store[p*NATS+j]);
            if (diff < 0) diff = -diff;
            sq_dist += longint'(diff) * longint'(diff);
         end
         d16 = sq_dist >> 14;
         a = (d16 >> 24) * kernel_scale + (((d16 & 64'hFF_FFFF) * kernel_scale) >> 24);
         if (a >= (64'd1 << 20)) begin
            w = 0;
         end else begin
            acc = 64'd1 << 30;
            for (int k = 0; k < EXP_STEPS; k++)
               if (a[k]) acc = (acc * EXP_TABLE[k] + (64'd1 << 29)) >> 30;
            w = (acc + (64'd1 << 13)) >> 14;
         end
         wsum += longint'(w) * longint'(target_store[p]);
         wsum_sum += w;
      end
      if (wsum_sum == 0) begin
         est.prediction = '0;
         est.zero_weight = 1'b1;
      end else begin
         wsum_mag = (wsum < 0) ? -wsum : wsum;
         q = (wsum_mag + wsum_sum / 2) / wsum_sum;
         if (wsum < 0) est.prediction = (q > 8388608) ? -24'sd8388608 : -q;
         else est.prediction = (q > 8388607) ? 24'sd8388607 : q;
         est.zero_weight = 1'b0;
      end
      return est;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         point_count <= '0;
         attribute_count <= 7'd1;
         kernel_scale <= KERNEL_SCALE_RESET;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_POINT_COUNT:     point_count <= pwdata[9:0];
               REG_ATTRIBUTE_COUNT: attribute_count <= pwdata[6:0];
               REG_KERNEL_SCALE:    kernel_scale <= pwdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (req.func)
               FUNC_LOAD_ATTR:
                  attr_store[req.point_index*NATS+req.attribute_index] = req.sample_value;
               FUNC_LOAD_TARGET: target_store[req.point_index] = req.sample_value;
               FUNC_QUERY: begin
                  query_store[req.attribute_index] = req.sample_value;
                  if (req.query_last) estimates.push_back(predict_mean());
               end
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (estimates.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0b with nothing expected",
                                         rsp.prediction, rsp.zero_weight));
            end else if (rsp.prediction !== estimates[0].prediction ||
                         rsp.zero_weight !== estimates[0].zero_weight) begin
               report_mismatch($sformatf("expected %0d/%0b, got %0d/%0b",
                                         estimates[0].prediction, estimates[0].zero_weight,
                                         rsp.prediction, rsp.zero_weight));
               void'(estimates.pop_front());
            end else begin
               void'(estimates.pop_front());
            end
         end
      end
   end
endmodule

>>> test/tb_grnn_kernel_regression_top.sv
module tb_grnn_kernel_regression_top;
   import gkr_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 200000;
   localparam int ITEM_GOAL = 700;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int error_count, pending_count;
   int items_sent;
   int stall_cycles;
   bit no_idle;
   bit attr_written [512*64];
   bit target_written [512];

   gkr_req_if req_ch ();
   gkr_rsp_if rsp_ch ();

   grnn_kernel_regression_top dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite), .paddr(csr_paddr),
      .pwdata(csr_pwdata), .prdata(csr_prdata), .pready(csr_pready)
   );

   gkr_checker checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite), .pready(csr_pready),
      .paddr(csr_paddr), .pwdata(csr_pwdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The result side holds ready low for a random gap, possibly none, before each item.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   function automatic int draw_value(input int mode);
      int v;
      case (mode)
         0: begin
            v = $urandom & 24'hFF_FFFF;
            if (v >= 24'h80_0000) v -= 32'h100_0000;
         end
         1: v = $urandom_range(0, 4000) - 2000;
         default: v = $urandom_range(0, 1) ? 8388607 : -8388608;
      endcase
      return v;
   endfunction

   task automatic send_item(input logic [1:0] f, input int p, input int a, input int v,
                            input bit last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.point_index <= 9'(p);
      req_ch.attribute_index <= 6'(a);
      req_ch.sample_value <= 24'(v);
      req_ch.query_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (f != FUNC_UNUSED) items_sent++;
      if (f == FUNC_LOAD_ATTR) attr_written[p*64+a] = 1'b1;
      if (f == FUNC_LOAD_TARGET) target_written[p] = 1'b1;
   endtask

   // Sometimes sends an item with an unused function code, which the block must ignore.
   task automatic maybe_noise();
      if ($urandom_range(0, 15) == 0)
         send_item(FUNC_UNUSED, $urandom_range(0, 511), $urandom_range(0, 63),
                   draw_value(0), $urandom_range(0, 1));
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // The checker counts a query only after its accepting edge, so the task
   // waits past that edge before the pending count is trusted.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Program the registers, load every entry that the evaluation reads and that
   // is not yet written (all of them for a small set), then run nq complete queries.
   task automatic run_phase(input int pc, input int ac, input logic [31:0] scale,
                            input int nq, input int mode);
      int np, na;
      wait_idle();
      csr_write(REG_POINT_COUNT, pc);
      csr_write(REG_ATTRIBUTE_COUNT, ac);
      csr_write(REG_KERNEL_SCALE, scale);
      if ($urandom_range(0, 3) == 0) csr_write(REG_UNUSED, $urandom);
      np = (pc > 512) ? 512 : pc;
      na = (ac > 64) ? 64 : ac;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int p = 0; p < np; p++)
         for (int j = 0; j < na; j++)
            if (!attr_written[p*64+j] || np * na <= 64) begin
               maybe_noise();
               send_item(FUNC_LOAD_ATTR, p, j, draw_value(mode), $urandom_range(0, 1));
            end
      for (int p = 0; p < np; p++)
         if (!target_written[p] || np <= 64) begin
            maybe_noise();
            send_item(FUNC_LOAD_TARGET, p, $urandom_range(0, 63),
                      draw_value(mode == 1 ? 0 : mode), $urandom_range(0, 1));
         end
      for (int q = 0; q < nq; q++) begin
         for (int j = 0; j < na; j++) begin
            maybe_noise();
            send_item(FUNC_QUERY, $urandom_range(0, 511), j, draw_value(mode), 1'b0);
         end
         send_item(FUNC_QUERY, $urandom_range(0, 511), $urandom_range(0, 63),
                   draw_value(mode), 1'b1);
      end
   endtask

   function automatic logic [31:0] draw_scale();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         3: return $urandom_range(32'h1_0000, 32'h100_0000);
         default: return KERNEL_SCALE_RESET;
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      no_idle = 1'b0;
      items_sent = 0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_LOAD_ATTR;
      req_ch.point_index = '0;
      req_ch.attribute_index = '0;
      req_ch.sample_value = '0;
      req_ch.query_last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first phase, with no points in use, gives the zero-weight flag.
      run_phase(0, 1, KERNEL_SCALE_RESET, 1, 1);
      run_phase(1, 1, 32'd0, 2, 2);
      run_phase(3, 2, KERNEL_SCALE_RESET, 2, 1);
      run_phase(2, 0, 32'hFFFF_FFFF, 1, 2);

      // The largest attribute count, then a count beyond it (127), which saturates.
      run_phase(2, 64, 32'h1_0000, 2, 1);
      run_phase(2, 127, draw_scale(), 2, 0);

      while (items_sent < ITEM_GOAL)
         run_phase($urandom_range(0, 8), $urandom_range(0, 6), draw_scale(),
                   $urandom_range(2, 6), $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 2));

      wait_idle();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
